FILE: sv/fgn_pkg.sv
package fgn_pkg;

  localparam int MAX_OCTAVES_DEF     = 8;
  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SEED         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_DIM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LACUNARITY   = 3'd4;

  localparam logic [31:0] SEED_RST        = 32'd0;
  localparam logic [3:0]  OCTAVE_CNT_RST  = 4'd1;
  localparam logic [15:0] PERSISTENCE_RST = 16'd32768;
  localparam logic [15:0] LACUNARITY_RST  = 16'd8192;

  localparam int OCT_CNT_W = 5;

  localparam int NOISE_W = 20;
  localparam int DIFF_W  = NOISE_W + 1;
  localparam int FADE_W  = 17;
  localparam int OFF_W   = 17;
  localparam int AMP_W   = 17;
  localparam int PROD_W  = NOISE_W + AMP_W + 1;
  localparam int LP_W    = DIFF_W + FADE_W + 1;
  localparam int QUOT_W  = 20;

  localparam logic [31:0]      FREQ_ONE = 32'd4096;
  localparam logic [AMP_W-1:0] AMP_ONE  = 17'd65536;

  localparam logic [31:0] HASH_MX  = 32'd374761393;
  localparam logic [31:0] HASH_MY  = 32'd668265263;
  localparam logic [31:0] HASH_MZ  = 32'd137561653;
  localparam logic [31:0] HASH_MIX = 32'd1274126177;
  localparam int          HASH_SHIFT = 13;
  localparam logic [31:0] HASH_M [3] = '{HASH_MX, HASH_MY, HASH_MZ};

  localparam logic signed [15:0] Q114_MAX = 16'sh7fff;
  localparam logic signed [15:0] Q114_MIN = 16'sh8000;

  // only the low four hash bits pick a gradient
  function automatic logic [3:0] mix4(input logic [31:0] h);
    logic [31:0] g;
    g = h ^ (h >> HASH_SHIFT);
    return 4'(g[3:0] * HASH_MIX[3:0]);
  endfunction

  function automatic logic signed [NOISE_W-1:0] grad(
    input logic [3:0] h,
    input logic is3,
    input logic signed [OFF_W-1:0] x,
    input logic signed [OFF_W-1:0] y,
    input logic signed [OFF_W-1:0] z
  );
    logic signed [NOISE_W-1:0] u;
    logic signed [NOISE_W-1:0] v;
    if (is3) begin
      u = (h < 4'd8) ? NOISE_W'(x) : NOISE_W'(y);
      if (h < 4'd4) begin
        v = NOISE_W'(y);
      end else if (h == 4'd12 || h == 4'd14) begin
        v = NOISE_W'(x);
      end else begin
        v = NOISE_W'(z);
      end
    end else begin
      u = h[1] ? NOISE_W'(y) : NOISE_W'(x);
      v = h[1] ? NOISE_W'(x) : NOISE_W'(y);
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [NOISE_W-1:0] lerp(
    input logic [FADE_W-1:0] w,
    input logic signed [NOISE_W-1:0] a,
    input logic signed [NOISE_W-1:0] b
  );
    logic signed [DIFF_W-1:0] d;
    logic signed [LP_W-1:0]   p;
    d = DIFF_W'(b) - DIFF_W'(a);
    p = d * $signed({1'b0, w});
    return a + NOISE_W'(p >>> 16);
  endfunction

endpackage

FILE: sv/fractal_gradient_noise_core.sv
// The pipeline is one ten-stage cell per octave, a divider front register, one divider
// cell per quotient bit, and the output register.
// Throughput: one item per cycle; the chain stalls only while a result waits in the
// output register and the last divider stage is also full.
// Reset (synchronous) clears all valid flags and loads the register defaults.
module fractal_gradient_noise_core #(
  parameter int MAX_OCTAVES     = fgn_pkg::MAX_OCTAVES_DEF,
  parameter int COORD_FRAC_BITS = fgn_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [95:0]                     s_tdata,  // x_coord, y_coord, z_coord
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,  // noise_value
  input  logic                            cfg_we,
  input  logic [fgn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fgn_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fgn_pkg::*;

  localparam int TOTAL_W = PROD_W + $clog2(MAX_OCTAVES);
  localparam int ASUM_W  = AMP_W + $clog2(MAX_OCTAVES);
  localparam int REM_W   = TOTAL_W;

  logic [31:0] seed;
  logic        three_dim;
  logic [3:0]  octave_count;
  logic [15:0] persistence;
  logic [15:0] lacunarity;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= SEED_RST;
      three_dim    <= 1'b0;
      octave_count <= OCTAVE_CNT_RST;
      persistence  <= PERSISTENCE_RST;
      lacunarity   <= LACUNARITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:         seed         <= cfg_data;
        REG_THREE_DIM:    three_dim    <= cfg_data[0];
        REG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        REG_PERSISTENCE:  persistence  <= cfg_data[15:0];
        REG_LACUNARITY:   lacunarity   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [OCT_CNT_W-1:0] n_oct;

  always_comb begin
    if (three_dim || octave_count == 4'd0) begin
      n_oct = OCT_CNT_W'(1);
    end else if (OCT_CNT_W'(octave_count) > OCT_CNT_W'(MAX_OCTAVES)) begin
      n_oct = OCT_CNT_W'(MAX_OCTAVES);
    end else begin
      n_oct = OCT_CNT_W'(octave_count);
    end
  end

  logic adv;
  logic last_v;

  logic                      ch_valid [MAX_OCTAVES+1];
  logic signed [31:0]        ch_x     [MAX_OCTAVES+1];
  logic signed [31:0]        ch_y     [MAX_OCTAVES+1];
  logic signed [31:0]        ch_z     [MAX_OCTAVES+1];
  logic [31:0]               ch_freq  [MAX_OCTAVES+1];
  logic [AMP_W-1:0]          ch_amp   [MAX_OCTAVES+1];
  logic signed [TOTAL_W-1:0] ch_total [MAX_OCTAVES+1];
  logic [ASUM_W-1:0]         ch_asum  [MAX_OCTAVES+1];

  assign ch_valid[0] = s_tvalid;
  assign ch_x[0]     = s_tdata[31:0];
  assign ch_y[0]     = s_tdata[63:32];
  assign ch_z[0]     = s_tdata[95:64];
  assign ch_freq[0]  = FREQ_ONE;
  assign ch_amp[0]   = AMP_ONE;
  assign ch_total[0] = '0;
  assign ch_asum[0]  = '0;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    fgn_octave_cell #(
      .FRAC_BITS (COORD_FRAC_BITS),
      .TOTAL_W   (TOTAL_W),
      .ASUM_W    (ASUM_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .adv         (adv),
      .octave_on   (OCT_CNT_W'(k) < n_oct),
      .three_dim   (three_dim),
      .seed        (seed),
      .persistence (persistence),
      .lacunarity  (lacunarity),
      .in_valid    (ch_valid[k]),
      .in_x        (ch_x[k]),
      .in_y        (ch_y[k]),
      .in_z        (ch_z[k]),
      .in_freq     (ch_freq[k]),
      .in_amp      (ch_amp[k]),
      .in_total    (ch_total[k]),
      .in_asum     (ch_asum[k]),
      .out_valid   (ch_valid[k+1]),
      .out_x       (ch_x[k+1]),
      .out_y       (ch_y[k+1]),
      .out_z       (ch_z[k+1]),
      .out_freq    (ch_freq[k+1]),
      .out_amp     (ch_amp[k+1]),
      .out_total   (ch_total[k+1]),
      .out_asum    (ch_asum[k+1])
    );
  end

  // divider front: magnitude and shifted divisor
  logic                      dc_valid [QUOT_W+1];
  logic                      dc_neg   [QUOT_W+1];
  logic [REM_W-1:0]          dc_rem   [QUOT_W+1];
  logic [REM_W-1:0]          dc_dsh   [QUOT_W+1];
  logic [QUOT_W-1:0]         dc_quot  [QUOT_W+1];

  logic signed [TOTAL_W-1:0] tot_last;
  assign tot_last = ch_total[MAX_OCTAVES];

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_valid[0] <= 1'b0;
    end else if (adv) begin
      dc_valid[0] <= ch_valid[MAX_OCTAVES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc_neg[0]  <= tot_last[TOTAL_W-1];
      dc_rem[0]  <= tot_last[TOTAL_W-1] ? REM_W'(-tot_last) : REM_W'(tot_last);
      dc_dsh[0]  <= REM_W'(ch_asum[MAX_OCTAVES]) << (QUOT_W - 1);
      dc_quot[0] <= '0;
    end
  end

  for (genvar i = 0; i < QUOT_W; i++) begin : g_div
    fgn_div_cell #(
      .REM_W  (REM_W),
      .QUOT_W (QUOT_W)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (dc_valid[i]),
      .in_neg    (dc_neg[i]),
      .in_rem    (dc_rem[i]),
      .in_dsh    (dc_dsh[i]),
      .in_quot   (dc_quot[i]),
      .out_valid (dc_valid[i+1]),
      .out_neg   (dc_neg[i+1]),
      .out_rem   (dc_rem[i+1]),
      .out_dsh   (dc_dsh[i+1]),
      .out_quot  (dc_quot[i+1])
    );
  end

  // sign, floor to Q1.14, saturate
  logic signed [QUOT_W:0] q_signed;
  logic signed [QUOT_W:0] q_shift;
  logic signed [15:0]     q_sat;

  always_comb begin
    q_signed = dc_neg[QUOT_W] ? -$signed({1'b0, dc_quot[QUOT_W]})
                              : $signed({1'b0, dc_quot[QUOT_W]});
    q_shift  = q_signed >>> 2;
    if (q_shift > (QUOT_W+1)'(Q114_MAX)) begin
      q_sat = Q114_MAX;
    end else if (q_shift < (QUOT_W+1)'(Q114_MIN)) begin
      q_sat = Q114_MIN;
    end else begin
      q_sat = 16'(q_shift);
    end
  end

  assign last_v   = dc_valid[QUOT_W];
  assign adv      = !m_tvalid || m_tready || !last_v;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= last_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= q_sat;
    end
  end

endmodule

FILE: sv/fgn_octave_cell.sv
module fgn_octave_cell #(
  parameter int FRAC_BITS = fgn_pkg::COORD_FRAC_BITS_DEF,
  parameter int TOTAL_W   = 41,
  parameter int ASUM_W    = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          octave_on,
  input  logic                          three_dim,
  input  logic [31:0]                   seed,
  input  logic [15:0]                   persistence,
  input  logic [15:0]                   lacunarity,
  input  logic                          in_valid,
  input  logic signed [31:0]            in_x,
  input  logic signed [31:0]            in_y,
  input  logic signed [31:0]            in_z,
  input  logic [31:0]                   in_freq,
  input  logic [fgn_pkg::AMP_W-1:0]     in_amp,
  input  logic signed [TOTAL_W-1:0]     in_total,
  input  logic [ASUM_W-1:0]             in_asum,
  output logic                          out_valid,
  output logic signed [31:0]            out_x,
  output logic signed [31:0]            out_y,
  output logic signed [31:0]            out_z,
  output logic [31:0]                   out_freq,
  output logic [fgn_pkg::AMP_W-1:0]     out_amp,
  output logic signed [TOTAL_W-1:0]     out_total,
  output logic [ASUM_W-1:0]             out_asum
);
  import fgn_pkg::*;

  localparam int STAGES = 10;
  localparam int CTX    = STAGES - 1;
  localparam int EXT_W  = (44 + FRAC_BITS > 65) ? 44 + FRAC_BITS : 65;

  logic [STAGES-1:0] vld;

  logic signed [31:0]       xs [CTX];
  logic signed [31:0]       ys [CTX];
  logic signed [31:0]       zs [CTX];
  logic [31:0]              fq [CTX];
  logic [AMP_W-1:0]         am [CTX];
  logic [AMP_W-1:0]         an [CTX];
  logic signed [TOTAL_W-1:0] tt [CTX];
  logic [ASUM_W-1:0]        as [CTX];

  // stage 1: scale coordinates, split cell and fraction, next frequency and amplitude
  logic signed [31:0]       crd [3];
  logic signed [64:0]       cprod [3];
  logic signed [EXT_W-1:0]  cext [3];
  logic [FRAC_BITS+15:0]    fext [3];
  logic [47:0]              fprod;
  logic [35:0]              fsh;
  logic [32:0]              aprod;
  logic [31:0]              freq_next;

  logic [31:0]              s1_cell [3];
  logic [15:0]              s1_t [3];

  assign crd[0] = in_x;
  assign crd[1] = in_y;
  assign crd[2] = in_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cprod[a] = crd[a] * $signed({1'b0, in_freq});
      cext[a]  = EXT_W'(cprod[a]);
      fext[a]  = {cext[a][12+FRAC_BITS-1 -: FRAC_BITS], 16'b0};
    end
    fprod = in_freq * lacunarity;
    fsh   = fprod[47:12];
    freq_next = (|fsh[35:32]) ? 32'hffff_ffff : fsh[31:0];
    aprod = in_amp * persistence;
  end

  // stage 2: fade terms and per-axis hash products
  logic signed [20:0]       m6 [3];
  logic signed [37:0]       pa [3];
  logic [31:0]              tsq [3];
  logic signed [21:0]       s2_pa [3];
  logic [15:0]              s2_t2 [3];
  logic [31:0]              s2_h [3];
  logic [15:0]              s2_t [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      m6[a]  = 21'sd6 * $signed({5'b0, s1_t[a]}) - 21'sd983040;
      pa[a]  = m6[a] * $signed({1'b0, s1_t[a]});
      tsq[a] = s1_t[a] * s1_t[a];
    end
  end

  // stage 3
  logic [31:0]              t3p [3];
  logic [19:0]              s3_p [3];
  logic [15:0]              s3_t3 [3];
  logic [31:0]              s3_hv [3][2];
  logic [15:0]              s3_t [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      t3p[a] = s2_t2[a] * s2_t[a];
    end
  end

  // stage 4
  logic [35:0]              fdp [3];
  logic [FADE_W-1:0]        s4_fade [3];
  logic [3:0]               s4_hash [8];
  logic [15:0]              s4_t [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      fdp[a] = s3_t3[a] * s3_p[a];
    end
  end

  // stage 5 .. 10
  logic signed [OFF_W-1:0]   off [3][2];
  logic signed [NOISE_W-1:0] s5_g [8];
  logic [FADE_W-1:0]         s5_fade [3];
  logic signed [NOISE_W-1:0] s6_l1 [4];
  logic [FADE_W-1:0]         s6_fade [3];
  logic signed [NOISE_W-1:0] s7_l2 [2];
  logic [FADE_W-1:0]         s7_fz;
  logic signed [NOISE_W-1:0] s8_noise;
  logic signed [PROD_W-1:0]  s9_prod;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      off[a][0] = $signed({1'b0, s4_t[a]});
      off[a][1] = $signed({1'b0, s4_t[a]}) - 17'sd65536;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xs[0] <= in_x;
      ys[0] <= in_y;
      zs[0] <= in_z;
      fq[0] <= freq_next;
      am[0] <= in_amp;
      an[0] <= aprod[32:16];
      tt[0] <= in_total;
      as[0] <= in_asum;
      for (int i = 1; i < CTX; i++) begin
        xs[i] <= xs[i-1];
        ys[i] <= ys[i-1];
        zs[i] <= zs[i-1];
        fq[i] <= fq[i-1];
        am[i] <= am[i-1];
        an[i] <= an[i-1];
        tt[i] <= tt[i-1];
        as[i] <= as[i-1];
      end

      for (int a = 0; a < 3; a++) begin
        s1_cell[a] <= cext[a][12+FRAC_BITS+31 -: 32];
        s1_t[a]    <= 16'(fext[a] >> FRAC_BITS);

        s2_pa[a] <= 22'(pa[a] >>> 16);
        s2_t2[a] <= tsq[a][31:16];
        s2_h[a]  <= 32'(s1_cell[a] * HASH_M[a]);
        s2_t[a]  <= s1_t[a];

        s3_p[a]  <= 20'(s2_pa[a] + 22'sd655360);
        s3_t3[a] <= t3p[a][31:16];
        s3_t[a]  <= s2_t[a];

        s4_fade[a] <= FADE_W'(fdp[a] >> 16);
        s4_t[a]    <= s3_t[a];

        s5_fade[a] <= s4_fade[a];
        s6_fade[a] <= s5_fade[a];
      end

      s3_hv[0][0] <= s2_h[0] + seed;
      s3_hv[0][1] <= s2_h[0] + HASH_MX + seed;
      s3_hv[1][0] <= s2_h[1];
      s3_hv[1][1] <= s2_h[1] + HASH_MY;
      s3_hv[2][0] <= three_dim ? s2_h[2] : 32'd0;
      s3_hv[2][1] <= three_dim ? s2_h[2] + HASH_MZ : 32'd0;

      for (int c = 0; c < 8; c++) begin
        s4_hash[c] <= mix4(s3_hv[0][c[0]] + s3_hv[1][c[1]] + s3_hv[2][c[2]]);
        s5_g[c]    <= grad(s4_hash[c], three_dim,
                           off[0][c[0]], off[1][c[1]], off[2][c[2]]);
      end

      for (int j = 0; j < 4; j++) begin
        s6_l1[j] <= lerp(s5_fade[0], s5_g[2*j], s5_g[2*j+1]);
      end
      for (int j = 0; j < 2; j++) begin
        s7_l2[j] <= lerp(s6_fade[1], s6_l1[2*j], s6_l1[2*j+1]);
      end
      s7_fz <= s6_fade[2];

      s8_noise <= three_dim ? lerp(s7_fz, s7_l2[0], s7_l2[1]) : s7_l2[0];
      s9_prod  <= s8_noise * $signed({1'b0, am[7]});

      out_x     <= xs[CTX-1];
      out_y     <= ys[CTX-1];
      out_z     <= zs[CTX-1];
      out_freq  <= fq[CTX-1];
      out_amp   <= an[CTX-1];
      out_total <= tt[CTX-1] + (octave_on ? TOTAL_W'(s9_prod) : TOTAL_W'(0));
      out_asum  <= as[CTX-1] + (octave_on ? ASUM_W'(am[CTX-1]) : ASUM_W'(0));
    end
  end

  assign out_valid = vld[STAGES-1];

endmodule

FILE: sv/fgn_div_cell.sv
module fgn_div_cell #(
  parameter int REM_W  = 41,
  parameter int QUOT_W = fgn_pkg::QUOT_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic              in_neg,
  input  logic [REM_W-1:0]  in_rem,
  input  logic [REM_W-1:0]  in_dsh,
  input  logic [QUOT_W-1:0] in_quot,
  output logic              out_valid,
  output logic              out_neg,
  output logic [REM_W-1:0]  out_rem,
  output logic [REM_W-1:0]  out_dsh,
  output logic [QUOT_W-1:0] out_quot
);

  logic ge;
  assign ge = in_rem >= in_dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_neg  <= in_neg;
      out_rem  <= ge ? in_rem - in_dsh : in_rem;
      out_dsh  <= in_dsh >> 1;
      out_quot <= {in_quot[QUOT_W-2:0], ge};
    end
  end

endmodule

FILE: verif/fractal_gradient_noise_core_tb.sv
module fractal_gradient_noise_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fgn_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES = 600;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [95:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [15:0] m_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [95:0] coord_q[$];
  logic [15:0] noise_q[$];

  bit [31:0] m_seed;
  bit m_three_dim;
  bit [3:0] m_octaves;
  bit [15:0] m_persist;
  bit [15:0] m_lacun;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_cnt;
  int stall_cycles;
  int errors = 0;

  fractal_gradient_noise_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint fade_of(longint t);
    longint p;
    longint t2;
    longint t3;
    p = (((t * 6) - 15 * 65536) * t >>> 16) + 10 * 65536;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    return (t3 * p) >>> 16;
  endfunction

  function automatic longint blend(longint w, longint a, longint b);
    return a + (((b - a) * w) >>> 16);
  endfunction

  // gradient noise at one scaled point, Q.16
  function automatic longint lattice_noise(bit is3, longint sx, longint sy, longint sz);
    bit [31:0] corner_base[3];
    longint frac[3];
    longint fd[3];
    longint g[8];
    longint s[3];
    longint o[3];
    bit [31:0] h;
    bit [3:0] hi;
    longint u;
    longint v;
    int k;
    int ax;
    int ncorner;
    s[0] = sx; s[1] = sy; s[2] = sz;
    for (ax = 0; ax < 3; ax++) begin
      corner_base[ax] = 32'(s[ax] >>> 16);
      frac[ax] = s[ax] & 64'hFFFF;
      fd[ax] = fade_of(frac[ax]);
    end
    ncorner = is3 ? 8 : 4;
    for (k = 0; k < ncorner; k++) begin
      for (ax = 0; ax < 3; ax++)
        o[ax] = k[ax] ? frac[ax] - 65536 : frac[ax];
      h = (corner_base[0] + 32'(k[0])) * HASH_MX +
          (corner_base[1] + 32'(k[1])) * HASH_MY + m_seed;
      if (is3) h = h + (corner_base[2] + 32'(k[2])) * HASH_MZ;
      h = (h ^ (h >> HASH_SHIFT)) * HASH_MIX;
      if (is3) begin
        hi = h[3:0];
        u = (hi < 8) ? o[0] : o[1];
        v = (hi < 4) ? o[1] : ((hi == 12 || hi == 14) ? o[0] : o[2]);
      end else begin
        hi = {2'b00, h[1:0]};
        u = (hi < 2) ? o[0] : o[1];
        v = (hi < 2) ? o[1] : o[0];
      end
      g[k] = (hi[0] ? -u : u) + (hi[1] ? -v : v);
    end
    if (!is3)
      return blend(fd[1], blend(fd[0], g[0], g[1]), blend(fd[0], g[2], g[3]));
    return blend(fd[2],
                 blend(fd[1], blend(fd[0], g[0], g[1]), blend(fd[0], g[2], g[3])),
                 blend(fd[1], blend(fd[0], g[4], g[5]), blend(fd[0], g[6], g[7])));
  endfunction

  function automatic logic [15:0] predict_noise(logic [95:0] c);
    longint x;
    longint y;
    longint z;
    longint freq;
    longint amp;
    longint amp_sum;
    longint total;
    longint q;
    int n;
    int i;
    x = longint'($signed(c[31:0]));
    y = longint'($signed(c[63:32]));
    z = longint'($signed(c[95:64]));
    if (m_three_dim) begin
      q = lattice_noise(1'b1, x, y, z);
    end else begin
      n = int'(m_octaves);
      if (n == 0) n = 1;
      if (n > MAX_OCTAVES_DEF) n = MAX_OCTAVES_DEF;
      freq = 4096; amp = 65536; amp_sum = 0; total = 0;
      for (i = 0; i < n; i++) begin
        total += lattice_noise(1'b0, (x * freq) >>> 12, (y * freq) >>> 12, 0) * amp;
        amp_sum += amp;
        amp = (amp * m_persist) >> 16;
        freq = (freq * m_lacun) >> 12;
        if (freq > 64'hFFFFFFFF) freq = 64'hFFFFFFFF;
      end
      q = total / amp_sum;
    end
    q = q >>> 2;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready)
        noise_q.push_back(predict_noise(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (coord_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata <= coord_q.pop_front();
          s_tvalid <= 1;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // receiver, checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      hold_cnt <= 0;
      stall_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (noise_q.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, m_tdata);
          errors++;
        end else if (noise_q[0] !== m_tdata) begin
          $display("%0t: noise_value mismatch, expected %h actual %h",
                   $time, noise_q[0], m_tdata);
          errors++;
          void'(noise_q.pop_front());
        end else begin
          void'(noise_q.pop_front());
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt <= HOLD_CYCLES;
        m_tready <= 0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (coord_q.size() == 0 && noise_q.size() == 0 && !s_tvalid)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SEED: m_seed = val;
      REG_THREE_DIM: m_three_dim = val[0];
      REG_OCTAVE_COUNT: m_octaves = val[3:0];
      REG_PERSISTENCE: m_persist = val[15:0];
      REG_LACUNARITY: m_lacun = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_config(logic [31:0] sd, bit d3, logic [3:0] oc,
                            logic [15:0] pe, logic [15:0] la);
    write_reg(REG_SEED, sd);
    write_reg(REG_THREE_DIM, 32'(d3));
    write_reg(REG_OCTAVE_COUNT, 32'(oc));
    write_reg(REG_PERSISTENCE, 32'(pe));
    write_reg(REG_LACUNARITY, 32'(la));
  endtask

  task automatic drain();
    while (coord_q.size() > 0 || noise_q.size() > 0 || s_tvalid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32 << 16)) - (32'd16 << 16);
      2: return ($urandom_range(0, 64) - 32) * 65536 +
                (($urandom_range(1)) ? 32'hFFFF : 32'h0);
      default: return 32'($urandom_range(0, 1 << 20)) - (32'd1 << 19);
    endcase
  endfunction

  task automatic push_random(int count);
    int i;
    for (i = 0; i < count; i++)
      coord_q.push_back({rand_coord(), rand_coord(), rand_coord()});
  endtask

  task automatic random_phase(int count);
    logic [15:0] la;
    logic [3:0] oc;
    oc = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
    la = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 12288));
    set_config($urandom, $urandom_range(3) == 0, oc, 16'($urandom), la);
    push_random(count);
    drain();
  endtask

  initial begin
    int p;
    logic [31:0] edge_vals[8];
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 0;
    send_idle_pct = 25;
    recv_idle_pct = 49;
    m_seed = SEED_RST;
    m_three_dim = 0;
    m_octaves = OCTAVE_CNT_RST;
    m_persist = PERSISTENCE_RST;
    m_lacun = LACUNARITY_RST;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset defaults first, edge coordinates
    edge_vals = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                  32'h00010000, 32'hFFFF0000, 32'h0000FFFF, 32'h00008000};
    for (p = 0; p < 8; p++)
      coord_q.push_back({edge_vals[7 - p], edge_vals[(p + 3) % 8], edge_vals[p]});
    drain();
    // zero octaves, index beyond the list is ignored
    set_config(32'hFFFFFFFF, 1'b0, 4'd0, 16'hFFFF, 16'hFFFF);
    write_reg(3'd5, 32'hFFFFFFFF);
    write_reg(3'd7, 32'h0);
    for (p = 0; p < 4; p++) coord_q.push_back({edge_vals[p], edge_vals[p + 4], edge_vals[p]});
    drain();
    // octaves above max, huge frequency, zero persistence
    set_config(32'h12345678, 1'b0, 4'd15, 16'h0000, 16'hFFFF);
    for (p = 0; p < 4; p++) coord_q.push_back({edge_vals[p], edge_vals[p], edge_vals[p + 4]});
    drain();
    // zero lacunarity, full octaves
    set_config(32'h0, 1'b0, 4'd8, 16'hFFFF, 16'h0000);
    push_random(3);
    drain();
    // 3D mode
    set_config(32'hA5A5A5A5, 1'b1, 4'd1, PERSISTENCE_RST, LACUNARITY_RST);
    for (p = 0; p < 6; p++) coord_q.push_back({edge_vals[p + 2], edge_vals[p], edge_vals[p + 1]});
    drain();

    for (p = 0; p < 3; p++) random_phase(130);
    send_idle_pct = 49;
    recv_idle_pct = 25;
    for (p = 0; p < 3; p++) random_phase(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(130);
    @(posedge clk);
    hold_req <= 1;
    @(posedge clk);
    hold_req <= 0;
    random_phase(200);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/fgn_pkg.sv
sv/fgn_octave_cell.sv
sv/fgn_div_cell.sv
sv/fractal_gradient_noise_core.sv
verif/fractal_gradient_noise_core_tb.sv
